FILE: design/audio_beat_detector_defines.svh
// Assertion macros for the audio beat detector.
`ifndef AUDIO_BEAT_DETECTOR_DEFINES_SVH
`define AUDIO_BEAT_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ABD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ABD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/abd_pkg.sv
// Shared types, constants and functions of the audio beat detector.
`timescale 1ns / 1ps
package abd_pkg;

  localparam int LEVEL_FRAC_BITS = 4;
  localparam int RING_BLOCKS     = 4096;
  localparam int IDX_W           = $clog2(RING_BLOCKS);

  localparam int SAMPLE_W   = 8;
  localparam int LVL_W      = 14;
  localparam int SUM_W      = 17;
  localparam int SPB_W      = 10;
  localparam int FALL_W     = 10;
  localparam int CFG_DATA_W = 14;
  localparam int CFG_IDX_W  = 2;

  localparam int LEVEL_MAX  = 640 << LEVEL_FRAC_BITS;
  localparam int LEVEL_MULT = 5 << LEVEL_FRAC_BITS;
  localparam int NUM_W      = SUM_W + $clog2(LEVEL_MULT + 1);

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [SPB_W-1:0]  SPB_RESET     = SPB_W'(500);
  localparam logic [LVL_W-1:0]  MIN_THR_RESET = LVL_W'(800);
  localparam logic [LVL_W-1:0]  PEAK_OFS_RESET = LVL_W'(640);
  localparam logic [FALL_W-1:0] FALLOFF_RESET = FALL_W'(35);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPB      = 2'd0,
    REG_MIN_THR  = 2'd1,
    REG_PEAK_OFS = 2'd2,
    REG_FALLOFF  = 2'd3
  } cfg_reg_t;

  // Effective settings; zero block size and zero falloff already mapped to 1.
  typedef struct packed {
    logic [SPB_W-1:0]  spb;
    logic [LVL_W-1:0]  min_thr;
    logic [LVL_W-1:0]  peak_ofs;
    logic [FALL_W-1:0] falloff;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LEVEL,
    ST_CHECK,
    ST_MUL_A,
    ST_MUL_B,
    ST_COMPARE,
    ST_OUT
  } back_state_t;

  // 128 - |b - 127|, range 0..128
  function automatic logic [SAMPLE_W-1:0] loudness(input logic [SAMPLE_W-1:0] b);
    logic [SAMPLE_W-1:0] mag;
    mag = (b >= SAMPLE_W'(127)) ? (b - SAMPLE_W'(127)) : (SAMPLE_W'(127) - b);
    return SAMPLE_W'(128) - mag;
  endfunction

endpackage

FILE: design/abd_channels.sv
// Channel interfaces of the audio beat detector: samples, results, config writes.
`timescale 1ns / 1ps
interface abd_sample_if import abd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_byte;

  modport source (output valid, output sample_byte, input ready);
  modport sink   (input valid, input sample_byte, output ready);
endinterface

interface abd_result_if import abd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LVL_W-1:0] latest_level;
  logic [LVL_W-1:0] decided_level;
  logic [IDX_W-1:0] decided_index;
  logic             beat;

  modport source (output valid, output latest_level, output decided_level,
                  output decided_index, output beat, input ready);
  modport sink   (input valid, input latest_level, input decided_level,
                  input decided_index, input beat, output ready);
endinterface

interface abd_cfg_if import abd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

FILE: design/abd_front.sv
// Front end: takes sample beats, accumulates loudness, pushes each finished block sum.
`timescale 1ns / 1ps
module abd_front import abd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  abd_sample_if.sink       samples,
  output logic             push_valid,
  input  logic             push_ready,
  output logic [SUM_W-1:0] push_sum
);

  logic [SPB_W-1:0] count;
  logic [SUM_W-1:0] sum;
  logic [SPB_W:0]   count_inc;
  logic [SUM_W-1:0] sum_inc;
  logic             accept;
  logic             block_end;

  assign samples.ready = push_ready;
  assign accept        = samples.valid && samples.ready;
  assign count_inc     = {1'b0, count} + (SPB_W + 1)'(1);
  assign sum_inc       = sum + SUM_W'(loudness(samples.sample_byte));
  // count can already be past a lowered block size; >= closes the block then
  assign block_end     = count_inc >= {1'b0, cfg.spb};
  assign push_valid    = accept && block_end;
  assign push_sum      = sum_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sum   <= '0;
    end else if (accept) begin
      if (block_end) begin
        count <= '0;
        sum   <= '0;
      end else begin
        count <= count_inc[SPB_W-1:0];
        sum   <= sum_inc;
      end
    end
  end

endmodule

FILE: design/abd_queue.sv
// Short FIFO of block sums between the front and back ends.
`timescale 1ns / 1ps
module abd_queue import abd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [SUM_W-1:0] push_sum,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [SUM_W-1:0] pop_sum
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [SUM_W-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = fill != CNT_W'(DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_sum    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

FILE: design/abd_back.sv
// Back end: block level division, beat decision and the result output register.
`timescale 1ns / 1ps
module abd_back import abd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  logic [SUM_W-1:0] pop_sum,
  abd_result_if.source     results
);

  localparam int TOP_W  = LVL_W + 1;
  localparam int DIFF_W = LVL_W + 2;
  localparam int PA_W   = DIFF_W + FALL_W + 1;
  localparam int PB_W   = DIFF_W + IDX_W + 1;
  localparam int ACC_W  = ((PA_W > PB_W) ? PA_W : PB_W) + 1;
  localparam int DCMP_W = (IDX_W > FALL_W) ? IDX_W : FALL_W;
  localparam int BCNT_W = $clog2(NUM_W);

  back_state_t state, state_next;

  // division
  logic [NUM_W-1:0]  num_sr;
  logic [SPB_W-1:0]  rem;
  logic [BCNT_W-1:0] bit_cnt;
  logic [SPB_W:0]    rem_sh;
  logic [SPB_W:0]    rem_diff;
  logic              sub_ok;

  // decision
  logic [LVL_W-1:0]        lvl;
  logic                    beat_r;
  logic [IDX_W-1:0]        ring_gap;
  logic [TOP_W-1:0]        top;
  logic signed [PA_W-1:0]  prod_a;
  logic signed [PB_W-1:0]  prod_b;
  logic [IDX_W-1:0]        cand_idx;
  logic [IDX_W-1:0]        dist_c;
  logic [TOP_W-1:0]        top_c;
  logic                    pass_basic;
  logic                    ramp;
  logic signed [DIFF_W-1:0] diff_a;
  logic signed [DIFF_W-1:0] span;
  logic signed [FALL_W:0]   fall_s;
  logic signed [IDX_W:0]    dist_s;
  logic signed [PA_W-1:0]   mul_a;
  logic signed [PB_W-1:0]   mul_b;
  logic signed [ACC_W-1:0]  acc;

  // block history
  logic [LVL_W-1:0] prev_level;
  logic [LVL_W-1:0] cand_level;
  logic [IDX_W-1:0] block_cnt;
  logic [IDX_W-1:0] last_beat_idx;
  logic [LVL_W-1:0] last_beat_level;
  logic             have_beat;
  logic             have_cand;

  // output register
  logic             res_valid;
  logic [LVL_W-1:0] res_latest;
  logic [LVL_W-1:0] res_decided;
  logic [IDX_W-1:0] res_index;
  logic             res_beat;
  logic             out_load;

  assign rem_sh   = {rem, num_sr[NUM_W-1]};
  assign sub_ok   = rem_sh >= {1'b0, cfg.spb};
  assign rem_diff = rem_sh - {1'b0, cfg.spb};

  assign cand_idx   = block_cnt - IDX_W'(1);
  assign dist_c     = cand_idx - last_beat_idx;
  assign top_c      = TOP_W'(last_beat_level) + TOP_W'(cfg.peak_ofs);
  assign pass_basic = have_cand && (cand_level >= prev_level) && (cand_level >= lvl)
                      && (cand_level > cfg.min_thr);
  assign ramp       = have_beat && (DCMP_W'(dist_c) <= DCMP_W'(cfg.falloff));

  // level*F + d*(top - min) > top*F  rewritten as  (level - top)*F + d*(top - min) > 0
  assign diff_a = $signed(DIFF_W'(cand_level) - DIFF_W'(top));
  assign span   = $signed(DIFF_W'(top) - DIFF_W'(cfg.min_thr));
  assign fall_s = $signed({1'b0, cfg.falloff});
  assign dist_s = $signed({1'b0, ring_gap});
  assign mul_a  = PA_W'(diff_a) * PA_W'(fall_s);
  assign mul_b  = PB_W'(span) * PB_W'(dist_s);
  assign acc    = ACC_W'(prod_a) + ACC_W'(prod_b);

  assign out_load = (state == ST_OUT) && (!res_valid || results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (bit_cnt == BCNT_W'(NUM_W - 1)) state_next = ST_LEVEL;
      end
      ST_LEVEL: state_next = ST_CHECK;
      ST_CHECK: begin
        state_next = (pass_basic && ramp) ? ST_MUL_A : ST_OUT;
      end
      ST_MUL_A:   state_next = ST_MUL_B;
      ST_MUL_B:   state_next = ST_COMPARE;
      ST_COMPARE: state_next = ST_OUT;
      ST_OUT: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        num_sr  <= NUM_W'(pop_sum) * NUM_W'(LEVEL_MULT);
        rem     <= '0;
        bit_cnt <= '0;
      end
      ST_DIV: begin
        num_sr  <= {num_sr[NUM_W-2:0], sub_ok};
        rem     <= sub_ok ? rem_diff[SPB_W-1:0] : rem_sh[SPB_W-1:0];
        bit_cnt <= bit_cnt + BCNT_W'(1);
      end
      ST_LEVEL: begin
        lvl <= (num_sr > NUM_W'(LEVEL_MAX)) ? LVL_W'(LEVEL_MAX) : num_sr[LVL_W-1:0];
      end
      ST_CHECK: begin
        beat_r   <= pass_basic && !ramp;
        ring_gap <= dist_c;
        top      <= top_c;
      end
      ST_MUL_A: prod_a <= mul_a;
      ST_MUL_B: prod_b <= mul_b;
      ST_COMPARE: beat_r <= !acc[ACC_W-1] && (acc != '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level      <= '0;
      cand_level      <= '0;
      block_cnt       <= '0;
      last_beat_idx   <= '0;
      last_beat_level <= '0;
      have_beat       <= 1'b0;
      have_cand       <= 1'b0;
      res_valid       <= 1'b0;
    end else begin
      if (out_load) begin
        res_valid   <= 1'b1;
        res_latest  <= lvl;
        res_decided <= have_cand ? cand_level : '0;
        res_index   <= have_cand ? cand_idx : '0;
        res_beat    <= have_cand && beat_r;
        if (have_cand && beat_r) begin
          have_beat       <= 1'b1;
          last_beat_idx   <= cand_idx;
          last_beat_level <= cand_level;
        end
        prev_level <= cand_level;
        cand_level <= lvl;
        have_cand  <= 1'b1;
        block_cnt  <= block_cnt + IDX_W'(1);
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign results.valid         = res_valid;
  assign results.latest_level  = res_latest;
  assign results.decided_level = res_decided;
  assign results.decided_index = res_index;
  assign results.beat          = res_beat;

endmodule

FILE: design/audio_beat_detector.sv
// Flow: each block sum passes the queue to the back end, which divides it, clamps the level,
//   checks the candidate, and runs the ramp multiply and compare only when the ramp applies.
// Throughput: one sample per cycle while the queue has room; the back end works on one block
//   at a time in its bit-serial restoring divider and decision states, with the queue absorbing bursts.
// Reset (rst, synchronous, active high) restores register defaults and clears all history.
`timescale 1ns / 1ps
`include "audio_beat_detector_defines.svh"
module audio_beat_detector import abd_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  abd_cfg_if.sink      cfg,
  abd_sample_if.sink   samples,
  abd_result_if.source results
);

  logic [SPB_W-1:0]  spb_q;
  logic [LVL_W-1:0]  min_thr_q;
  logic [LVL_W-1:0]  peak_ofs_q;
  logic [FALL_W-1:0] falloff_q;
  cfg_t              cfg_eff;

  logic             push_valid;
  logic             push_ready;
  logic [SUM_W-1:0] push_sum;
  logic             pop_valid;
  logic             pop_ready;
  logic [SUM_W-1:0] pop_sum;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      spb_q      <= SPB_RESET;
      min_thr_q  <= MIN_THR_RESET;
      peak_ofs_q <= PEAK_OFS_RESET;
      falloff_q  <= FALLOFF_RESET;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.reg_index))
        REG_SPB:      spb_q      <= cfg.wdata[SPB_W-1:0];
        REG_MIN_THR:  min_thr_q  <= cfg.wdata[LVL_W-1:0];
        REG_PEAK_OFS: peak_ofs_q <= cfg.wdata[LVL_W-1:0];
        REG_FALLOFF:  falloff_q  <= cfg.wdata[FALL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_eff.spb      = (spb_q == '0) ? SPB_W'(1) : spb_q;
    cfg_eff.min_thr  = min_thr_q;
    cfg_eff.peak_ofs = peak_ofs_q;
    cfg_eff.falloff  = (falloff_q == '0) ? FALL_W'(1) : falloff_q;
  end

  abd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_eff),
    .samples    (samples),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_sum   (push_sum)
  );

  abd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_sum   (push_sum),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_sum    (pop_sum)
  );

  abd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_eff),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_sum   (pop_sum),
    .results   (results)
  );

  `ABD_ASSERT_IMP(a_push_has_room, push_valid, push_ready, "block sum pushed into full queue")
  `ABD_ASSERT_NXT(a_one_block_busy, pop_valid && pop_ready, !pop_ready, "back end popped twice")
  `ABD_ASSERT_IMP(a_level_bound, results.valid, results.latest_level <= LVL_W'(LEVEL_MAX), "level above max")
  `ABD_ASSERT_IMP(a_beat_is_peak, results.valid && results.beat, results.decided_level >= results.latest_level, "beat below next block")

endmodule

FILE: verif/abd_beat_checker.sv
// Beat detector checker: tracks config writes, predicts each block result and compares.
`timescale 1ns / 1ps
module abd_beat_checker import abd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  abd_cfg_if    cfg,
  abd_sample_if samples,
  abd_result_if results,
  output int    mismatch_count,
  output int    blocks_pending
);

  localparam int FULL_SCALE = 640 << LEVEL_FRAC_BITS;
  localparam int PRINT_CAP  = 100;

  typedef struct packed {
    logic [LVL_W-1:0] latest_level;
    logic [LVL_W-1:0] decided_level;
    logic [IDX_W-1:0] decided_index;
    logic             beat;
  } block_result_t;

  block_result_t expected_blocks[$];

  logic [SPB_W-1:0]  spb_reg;
  logic [LVL_W-1:0]  min_thr_reg;
  logic [LVL_W-1:0]  peak_ofs_reg;
  logic [FALL_W-1:0] falloff_reg;

  int                samples_in_block;
  logic [SUM_W-1:0]  loud_sum;
  logic [LVL_W-1:0]  prev_level;
  logic [LVL_W-1:0]  cand_level;
  logic [IDX_W-1:0]  block_idx;
  logic [IDX_W-1:0]  beat_idx;
  logic [LVL_W-1:0]  beat_level;
  logic              beat_seen;
  logic              cand_valid;
  int                fails = 0;

  // Ramp test kept exact: lvl*F + d*(top - min) > top*F, flat at the minimum past F.
  function automatic logic is_beat(input logic [LVL_W-1:0] lvl, input logic [LVL_W-1:0] prior,
                                   input logic [LVL_W-1:0] next_lvl,
                                   input logic [IDX_W-1:0] idx);
    longint ramp_len;
    longint top;
    longint gap;
    if (lvl < prior || lvl < next_lvl || lvl <= min_thr_reg) return 1'b0;
    if (!beat_seen) return 1'b1;
    gap = longint'(IDX_W'(idx - beat_idx));
    ramp_len = (falloff_reg == '0) ? 64'sd1 : longint'(falloff_reg);
    if (gap > ramp_len) return 1'b1;
    top = longint'(beat_level) + longint'(peak_ofs_reg);
    return longint'(lvl) * ramp_len + gap * (top - longint'(min_thr_reg)) > top * ramp_len;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fails++;
    if (fails <= PRINT_CAP)
      $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic take_sample(input logic [SAMPLE_W-1:0] b);
    int            mag;
    int            eff_spb;
    longint        scaled;
    logic [LVL_W-1:0] lvl;
    block_result_t res;
    mag = (b >= 8'd127) ? int'(b) - 127 : 127 - int'(b);
    eff_spb = (spb_reg == '0) ? 1 : int'(spb_reg);
    loud_sum = loud_sum + SUM_W'(128 - mag);
    samples_in_block++;
    // a block size lowered below the count also ends the block here
    if (samples_in_block < eff_spb) return;
    scaled = longint'(loud_sum) * (5 << LEVEL_FRAC_BITS) / eff_spb;
    lvl = (scaled > FULL_SCALE) ? LVL_W'(FULL_SCALE) : LVL_W'(scaled);
    samples_in_block = 0;
    loud_sum = '0;
    res = '0;
    res.latest_level = lvl;
    if (cand_valid) begin
      res.decided_level = cand_level;
      res.decided_index = block_idx - IDX_W'(1);
      if (is_beat(cand_level, prev_level, lvl, res.decided_index)) begin
        res.beat = 1'b1;
        beat_seen = 1'b1;
        beat_idx = res.decided_index;
        beat_level = cand_level;
      end
    end
    prev_level = cand_level;
    cand_level = lvl;
    cand_valid = 1'b1;
    block_idx = block_idx + IDX_W'(1);
    expected_blocks.push_back(res);
  endtask

  task automatic check_block();
    block_result_t want;
    if (expected_blocks.size() == 0) begin
      report_mismatch("result beat with no block pending:", results.latest_level, 0);
      return;
    end
    want = expected_blocks.pop_front();
    if (results.latest_level !== want.latest_level)
      report_mismatch("latest_level", results.latest_level, want.latest_level);
    if (results.decided_level !== want.decided_level)
      report_mismatch("decided_level", results.decided_level, want.decided_level);
    if (results.decided_index !== want.decided_index)
      report_mismatch("decided_index", results.decided_index, want.decided_index);
    if (results.beat !== want.beat)
      report_mismatch("beat flag", results.beat, want.beat);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      spb_reg          = SPB_RESET;
      min_thr_reg      = MIN_THR_RESET;
      peak_ofs_reg     = PEAK_OFS_RESET;
      falloff_reg      = FALLOFF_RESET;
      samples_in_block = 0;
      loud_sum         = '0;
      prev_level       = '0;
      cand_level       = '0;
      block_idx        = '0;
      beat_idx         = '0;
      beat_level       = '0;
      beat_seen        = 1'b0;
      cand_valid       = 1'b0;
      expected_blocks.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.reg_index)
          REG_SPB:      spb_reg      = cfg.wdata[SPB_W-1:0];
          REG_MIN_THR:  min_thr_reg  = cfg.wdata[LVL_W-1:0];
          REG_PEAK_OFS: peak_ofs_reg = cfg.wdata[LVL_W-1:0];
          REG_FALLOFF:  falloff_reg  = cfg.wdata[FALL_W-1:0];
          default: ;
        endcase
      end
      if (results.valid && results.ready) check_block();
      if (samples.valid && samples.ready) take_sample(samples.sample_byte);
    end
    mismatch_count <= fails;
    blocks_pending <= expected_blocks.size();
  end

endmodule

FILE: verif/audio_beat_detector_tb.sv
// Beat detector testbench top: clock, reset, sample and config stimulus, result back-pressure.
`timescale 1ns / 1ps
module audio_beat_detector_tb;
  import abd_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int IDLE_PCT      = 15;

  logic clk;
  logic rst;
  logic calm;
  int   mismatch_count;
  int   blocks_pending;
  int   cycle_count = 0;
  int   hold_seq = 0;
  int   hold_seen = 0;
  int   hold_left = 0;

  abd_cfg_if    cfg_ch();
  abd_sample_if sample_ch();
  abd_result_if result_ch();

  audio_beat_detector dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .samples (sample_ch),
    .results (result_ch)
  );

  abd_beat_checker level_check (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg_ch),
    .samples        (sample_ch),
    .results        (result_ch),
    .mismatch_count (mismatch_count),
    .blocks_pending (blocks_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: long hold-off on request, otherwise random stalls unless calm.
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      result_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_ch.ready <= 1'b0;
    end else if (calm) begin
      result_ch.ready <= 1'b1;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic send_byte(input logic [SAMPLE_W-1:0] b);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.sample_byte <= b;
    @(posedge clk);
    while (sample_ch.ready !== 1'b1) @(posedge clk);
  endtask

  // Drop valid and wait until every pending block result is out.
  task automatic settle();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (blocks_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata <= value;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
  endtask

  // Upper wdata bits of the 10-bit registers are junk on purpose.
  task automatic configure(input int spb, input int min_thr, input int peak, input int fall);
    write_reg(REG_SPB, {(CFG_DATA_W-SPB_W)'($urandom), SPB_W'(spb)});
    write_reg(REG_MIN_THR, CFG_DATA_W'(min_thr));
    write_reg(REG_PEAK_OFS, CFG_DATA_W'(peak));
    write_reg(REG_FALLOFF, {(CFG_DATA_W-FALL_W)'($urandom), FALL_W'(fall)});
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] shaped_byte(input int loud, input int jitter);
    int mag;
    mag = 128 - loud + int'($urandom_range(2 * jitter)) - jitter;
    if (mag < 0) mag = 0;
    if (mag > 128) mag = 128;
    if ($urandom_range(1) == 1) return SAMPLE_W'(127 + mag);
    return (mag > 127) ? '0 : SAMPLE_W'(127 - mag);
  endfunction

  // Per block: loud hit, quiet stretch, repeat of the last level (ties), or plain noise.
  task automatic play(input int n_samples, input int block_len, input int hold_at);
    int loud;
    int jitter;
    int pick;
    bit noisy;
    loud = 64;
    jitter = 3;
    noisy = 1'b0;
    for (int i = 0; i < n_samples; i++) begin
      if (i == hold_at) hold_seq <= hold_seq + 1;
      if (i % block_len == 0) begin
        pick = $urandom_range(99);
        noisy = (pick < 25);
        jitter = 3;
        if (pick >= 25 && pick < 45) begin
          loud = $urandom_range(128, 100);
        end else if (pick >= 45 && pick < 60) begin
          jitter = 0;
        end else if (pick >= 60) begin
          loud = $urandom_range(70, 0);
        end
      end
      send_byte(noisy ? SAMPLE_W'($urandom_range(255)) : shaped_byte(loud, jitter));
    end
  endtask

  task automatic run_directed();
    logic [SAMPLE_W-1:0] corner_bytes [12] =
      '{8'd127, 8'd0, 8'd255, 8'd128, 8'd126, 8'd1, 8'd254, 8'd127, 8'd127, 8'd64, 8'd192,
        8'd127};
    logic [SAMPLE_W-1:0] zero_cfg_bytes [5] = '{8'd127, 8'd0, 8'd127, 8'd200, 8'd127};
    configure(1, 800, 640, 35);
    foreach (corner_bytes[k]) send_byte(corner_bytes[k]);
    settle();
    // zero block size and zero ramp length both behave as 1
    configure(0, 800, 640, 0);
    foreach (zero_cfg_bytes[k]) send_byte(zero_cfg_bytes[k]);
    settle();
    configure(4, 800, 640, 35);
    send_byte(8'd10);
    send_byte(8'd20);
    settle();
    // block size cut below the running count: next sample closes the block
    configure(1, 800, 640, 35);
    send_byte(8'd30);
    settle();
  endtask

  task automatic run_random();
    int spb;
    spb = $urandom_range(3, 1);
    configure(spb, 800, 640, 35);
    play(80, spb, 40);
    settle();

    calm <= 1'b1;
    configure(2, 0, 0, 1);
    play(40, 2, -1);
    settle();
    calm <= 1'b0;

    configure(3, 10240, 10240, 1023);
    play(36, 3, -1);
    settle();

    configure(1, 16383, 16383, 0);
    play(30, 1, -1);
    settle();

    configure(5, 400, 3000, 8);
    play(35, 5, -1);
    settle();
    play(35, 5, -1);
    settle();

    // one block at peak loudness, then a partial block cut short
    configure(80, 800, 640, 35);
    repeat (80) send_byte(8'd127);
    play(30, 80, -1);
    settle();
    configure(7, 800, 640, 35);
    play(28, 7, -1);
    settle();

    spb = $urandom_range(8, 4);
    configure(spb, 200, 500, 3);
    play(50, spb, -1);
    settle();

    // single-sample blocks with a long result hold-off in the middle
    configure(1, 1000, 2000, 20);
    play(90, 1, 30);
    settle();
  endtask

  initial begin
    rst <= 1'b1;
    calm <= 1'b0;
    sample_ch.valid <= 1'b0;
    sample_ch.sample_byte <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.reg_index <= REG_SPB;
    cfg_ch.wdata <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/abd_pkg.sv
design/abd_channels.sv
design/abd_front.sv
design/abd_queue.sv
design/abd_back.sv
design/audio_beat_detector.sv
verif/abd_beat_checker.sv
verif/audio_beat_detector_tb.sv
